// File: src/midi_track_event_parser_macros.svh
// Assertion macros for the track parser.
`ifndef MIDI_TRACK_EVENT_PARSER_MACROS_SVH
`define MIDI_TRACK_EVENT_PARSER_MACROS_SVH
`ifndef SYNTHESIS
`define MTP_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define MTP_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define MTP_ASSERT_IMP(label, clk, rst_n, a, c, msg)
`define MTP_ASSERT_NXT(label, clk, rst_n, a, c, msg)
`endif
`endif

// File: src/mtp_pkg.sv
`timescale 1ns / 1ps
package mtp_pkg;
  localparam int TICK_BITS_DEF = 48;
  localparam int FIFO_DEPTH = 4;

  localparam logic [2:0] K_CHANNEL = 3'd0;
  localparam logic [2:0] K_SYSTEM  = 3'd1;
  localparam logic [2:0] K_SX_HDR  = 3'd2;
  localparam logic [2:0] K_SX_BYTE = 3'd3;
  localparam logic [2:0] K_TEMPO   = 3'd4;
  localparam logic [2:0] K_EOT     = 3'd5;
  localparam logic [2:0] K_META    = 3'd6;
  localparam logic [2:0] K_ERROR   = 3'd7;

  localparam logic [3:0] E_NONE    = 4'd0;
  localparam logic [3:0] E_DELTA   = 4'd1;
  localparam logic [3:0] E_TRUNC   = 4'd2;
  localparam logic [3:0] E_RUNNING = 4'd3;
  localparam logic [3:0] E_META    = 4'd4;
  localparam logic [3:0] E_SYSEX   = 4'd5;
  localparam logic [3:0] E_SYSTEM  = 4'd6;
  localparam logic [3:0] E_CHANNEL = 4'd7;
  localparam logic [3:0] E_DATA    = 4'd8;

  localparam logic [7:0] META_EOT   = 8'h2f;
  localparam logic [7:0] META_TEMPO = 8'h51;
  localparam logic [7:0] ST_SYSEX   = 8'hf0;
  localparam logic [7:0] ST_ESC     = 8'hf7;
  localparam logic [7:0] ST_META    = 8'hff;

  // Data byte count of system common messages, by low nibble.
  function automatic logic [1:0] sys_len(input logic [3:0] lo);
    unique case (lo)
      4'h1, 4'h3: sys_len = 2'd1;
      4'h2:       sys_len = 2'd2;
      default:    sys_len = 2'd0;
    endcase
  endfunction

  // Record handed from the parser to the result side.
  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] order;
    logic [23:0] msg;
    logic [23:0] tempo;
    logic [27:0] len;
    logic [7:0]  pbyte;
    logic        plast;
    logic [3:0]  err;
  } rec_t;
endpackage

// File: src/mtp_front.sv
`timescale 1ns / 1ps
module mtp_front #(
  parameter int TICK_BITS = mtp_pkg::TICK_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 valid,
  input  logic [7:0]           data_byte,
  input  logic                 chunk_last,
  input  logic                 track_start,
  output logic                 rec_valid,
  output mtp_pkg::rec_t        rec,
  output logic [TICK_BITS-1:0] rec_tick
);
  import mtp_pkg::*;
  `include "midi_track_event_parser_macros.svh"

  localparam logic [3:0] PH_DELTA = 4'd0, PH_STATUS = 4'd1, PH_MTYPE = 4'd2,
    PH_MLEN = 4'd3, PH_MDATA = 4'd4, PH_SLEN = 4'd5, PH_SDATA = 4'd6,
    PH_SYS = 4'd7, PH_D1 = 4'd8, PH_D2 = 4'd9, PH_IDLE = 4'd10;
  localparam logic [TICK_BITS-1:0] TICK_MAX = '1;

  logic [3:0] ph_r, ph_nxt;
  logic [TICK_BITS-1:0] tick_r, tick_nxt;
  logic [27:0] q_r, q_nxt, rem_r, rem_nxt;
  logic [2:0] qc_r, qc_nxt;
  logic [7:0] rs_r, rs_nxt, cs_r, cs_nxt, d1_r, d1_nxt, mt_r, mt_nxt;
  logic [23:0] tp_r, tp_nxt;
  logic [31:0] ord_r, ord_nxt;
  logic done_r, done_nxt, err_r, err_nxt;

  logic [3:0] ph0;
  logic [TICK_BITS-1:0] tick0;
  logic [27:0] q0;
  logic [2:0] qc0;
  logic [7:0] rs0, cs0;
  logic [31:0] ord0;
  logic done0, err0;
  logic [27:0] qa;
  logic [2:0] qca;
  logic [TICK_BITS-1:0] qext, sum;
  logic [TICK_BITS:0] sum_w;
  logic [27:0] rem_dec;
  logic [23:0] tp_shift;

  always_comb begin
    ph0 = track_start ? PH_DELTA : ph_r;
    tick0 = track_start ? '0 : tick_r;
    q0 = track_start ? '0 : q_r;
    qc0 = track_start ? '0 : qc_r;
    rs0 = track_start ? '0 : rs_r;
    cs0 = track_start ? '0 : cs_r;
    ord0 = track_start ? '0 : ord_r;
    done0 = track_start ? 1'b0 : done_r;
    err0 = track_start ? 1'b0 : err_r;
    qa = {q0[20:0], data_byte[6:0]};
    qca = qc0 + 3'd1;
    qext = TICK_BITS'(qa);
    sum_w = {1'b0, tick0} + {1'b0, qext};
    sum = sum_w[TICK_BITS] ? TICK_MAX : sum_w[TICK_BITS-1:0];
    rem_dec = rem_r - 28'd1;
    tp_shift = {tp_r[15:0], data_byte};
  end

  always_comb begin
    logic [3:0] hi;
    logic fin, fl;
    logic [3:0] fcode;
    logic [2:0] fkind;
    logic [23:0] fmsg, ftempo;
    logic [27:0] flen;
    logic [7:0] fpb;
    logic fpl;
    logic meta_fin;
    logic [7:0] mtv;
    logic [27:0] mq;
    logic [23:0] mtp;
    ph_nxt = ph_r; tick_nxt = tick_r; q_nxt = q_r; qc_nxt = qc_r;
    rs_nxt = rs_r; cs_nxt = cs_r; d1_nxt = d1_r; mt_nxt = mt_r;
    tp_nxt = tp_r; rem_nxt = rem_r; ord_nxt = ord_r;
    done_nxt = done_r; err_nxt = err_r;
    fin = 1'b0; fl = 1'b0; fcode = E_NONE; fkind = K_CHANNEL;
    fmsg = '0; ftempo = '0; flen = '0; fpb = '0; fpl = 1'b0;
    meta_fin = 1'b0; mtv = mt_r; mq = q_r; mtp = tp_r;
    rec_valid = 1'b0; rec = '0;
    hi = 4'h0;
    if (valid) begin
      ph_nxt = ph0; tick_nxt = tick0; q_nxt = q0; qc_nxt = qc0;
      rs_nxt = rs0; cs_nxt = cs0; ord_nxt = ord0;
      done_nxt = done0; err_nxt = err0;
      if (!(ph0 == PH_IDLE || err0 || done0)) begin
        unique case (ph0)
          PH_DELTA: begin
            q_nxt = qa; qc_nxt = qca;
            if (data_byte[7]) begin
              if (qca >= 3'd4 || chunk_last) begin fl = 1'b1; fcode = E_DELTA; end
            end else begin
              tick_nxt = sum; q_nxt = '0; qc_nxt = '0;
              if (chunk_last) begin fl = 1'b1; fcode = E_TRUNC; end
              else ph_nxt = PH_STATUS;
            end
          end
          PH_STATUS: begin
            if (!data_byte[7]) begin
              if (!rs0[7] || rs0[7:4] == 4'hf) begin fl = 1'b1; fcode = E_RUNNING; end
              else begin
                cs_nxt = rs0; ord_nxt = ord0 + 32'd1; d1_nxt = data_byte;
                hi = rs0[7:4];
                if (hi == 4'hc || hi == 4'hd) begin
                  fin = 1'b1; fkind = K_CHANNEL; fmsg = {8'h00, data_byte, rs0};
                end else if (chunk_last) begin fl = 1'b1; fcode = E_CHANNEL; end
                else ph_nxt = PH_D2;
              end
            end else begin
              ord_nxt = ord0 + 32'd1; cs_nxt = data_byte;
              rs_nxt = (data_byte[7:4] != 4'hf) ? data_byte : 8'h00;
              q_nxt = '0; qc_nxt = '0;
              if (data_byte == ST_META) begin
                if (chunk_last) begin fl = 1'b1; fcode = E_META; end
                else ph_nxt = PH_MTYPE;
              end else if (data_byte == ST_SYSEX || data_byte == ST_ESC) begin
                if (chunk_last) begin fl = 1'b1; fcode = E_SYSEX; end
                else ph_nxt = PH_SLEN;
              end else if (data_byte[7:4] == 4'hf) begin
                if (sys_len(data_byte[3:0]) == 2'd0) begin fin = 1'b1; fkind = K_SYSTEM; end
                else if (chunk_last) begin fl = 1'b1; fcode = E_SYSTEM; end
                else begin rem_nxt = 28'(sys_len(data_byte[3:0])); ph_nxt = PH_SYS; end
              end else if (chunk_last) begin fl = 1'b1; fcode = E_CHANNEL; end
              else ph_nxt = PH_D1;
            end
          end
          PH_D1: begin
            d1_nxt = data_byte; hi = cs_r[7:4];
            if (hi == 4'hc || hi == 4'hd) begin
              if (data_byte[7]) begin fl = 1'b1; fcode = E_DATA; end
              else begin fin = 1'b1; fkind = K_CHANNEL; fmsg = {8'h00, data_byte, cs_r}; end
            end else if (chunk_last) begin fl = 1'b1; fcode = E_CHANNEL; end
            else ph_nxt = PH_D2;
          end
          PH_D2: begin
            if (d1_r[7] || data_byte[7]) begin fl = 1'b1; fcode = E_DATA; end
            else begin fin = 1'b1; fkind = K_CHANNEL; fmsg = {data_byte, d1_r, cs_r}; end
          end
          PH_MTYPE: begin
            mt_nxt = data_byte; q_nxt = '0; qc_nxt = '0;
            if (chunk_last) begin fl = 1'b1; fcode = E_META; end
            else ph_nxt = PH_MLEN;
          end
          PH_MLEN: begin
            q_nxt = qa; qc_nxt = qca;
            if (data_byte[7]) begin
              if (qca >= 3'd4 || chunk_last) begin fl = 1'b1; fcode = E_META; end
            end else begin
              tp_nxt = '0; rem_nxt = qa;
              if (qa == 28'd0) begin meta_fin = 1'b1; mq = qa; mtp = '0; end
              else if (chunk_last) begin fl = 1'b1; fcode = E_META; end
              else ph_nxt = PH_MDATA;
            end
          end
          PH_MDATA: begin
            if (mt_r == META_TEMPO) tp_nxt = tp_shift;
            rem_nxt = rem_dec;
            if (rem_dec == 28'd0) begin
              meta_fin = 1'b1; mq = q_r; mtp = (mt_r == META_TEMPO) ? tp_shift : tp_r;
            end else if (chunk_last) begin fl = 1'b1; fcode = E_META; end
          end
          PH_SLEN: begin
            q_nxt = qa; qc_nxt = qca;
            if (data_byte[7]) begin
              if (qca >= 3'd4 || chunk_last) begin fl = 1'b1; fcode = E_SYSEX; end
            end else begin
              rem_nxt = qa;
              if (qa == 28'd0) begin fin = 1'b1; fkind = K_SX_HDR; end
              else if (chunk_last) begin fl = 1'b1; fcode = E_SYSEX; end
              else begin
                ph_nxt = PH_SDATA; rec_valid = 1'b1;
                rec.kind = K_SX_HDR; rec.order = ord0 - 32'd1; rec.len = qa;
              end
            end
          end
          PH_SDATA: begin
            rem_nxt = rem_dec;
            if (rem_dec == 28'd0) begin
              fin = 1'b1; fkind = K_SX_BYTE; fpb = data_byte; fpl = 1'b1;
            end else if (chunk_last) begin fl = 1'b1; fcode = E_SYSEX; end
            else begin
              rec_valid = 1'b1; rec.kind = K_SX_BYTE;
              rec.order = ord0 - 32'd1; rec.pbyte = data_byte;
            end
          end
          PH_SYS: begin
            rem_nxt = rem_dec;
            if (rem_dec == 28'd0) begin fin = 1'b1; fkind = K_SYSTEM; end
            else if (chunk_last) begin fl = 1'b1; fcode = E_SYSTEM; end
          end
          default: ph_nxt = PH_IDLE;
        endcase
        // resolve meta end into a finish
        if (meta_fin) begin
          fin = 1'b1;
          if (mtv == META_EOT) fkind = K_EOT;
          else if (mtv == META_TEMPO && mq == 28'd3 && mtp != 24'd0) begin
            fkind = K_TEMPO; ftempo = mtp;
          end else fkind = K_META;
        end
        if (fl) begin
          err_nxt = 1'b1; ph_nxt = PH_IDLE; rec_valid = 1'b1;
          rec.kind = K_ERROR; rec.order = ord_nxt; rec.err = fcode;
        end else if (fin) begin
          ph_nxt = PH_DELTA;
          if (chunk_last || fkind == K_EOT) begin ph_nxt = PH_IDLE; done_nxt = 1'b1; end
          rec_valid = 1'b1; rec.kind = fkind; rec.order = ord_nxt - 32'd1;
          rec.msg = fmsg; rec.tempo = ftempo; rec.len = flen;
          rec.pbyte = fpb; rec.plast = fpl;
        end
      end
    end
    rec_tick = tick_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_DELTA; tick_r <= '0; q_r <= '0; qc_r <= '0; rs_r <= '0;
      cs_r <= '0; d1_r <= '0; mt_r <= '0; tp_r <= '0; rem_r <= '0;
      ord_r <= '0; done_r <= 1'b0; err_r <= 1'b0;
    end else begin
      ph_r <= ph_nxt; tick_r <= tick_nxt; q_r <= q_nxt; qc_r <= qc_nxt;
      rs_r <= rs_nxt; cs_r <= cs_nxt; d1_r <= d1_nxt; mt_r <= mt_nxt;
      tp_r <= tp_nxt; rem_r <= rem_nxt; ord_r <= ord_nxt;
      done_r <= done_nxt; err_r <= err_nxt;
    end
  end

  `MTP_ASSERT_NXT(a_err_idle, clk, rst_n, valid && rec_valid && rec.kind == K_ERROR,
    ph_r == PH_IDLE && err_r, "error did not park parser")
  `MTP_ASSERT_IMP(a_idle_quiet, clk, rst_n, valid && !track_start && (err_r || done_r),
    !rec_valid, "record from stopped track")
  `MTP_ASSERT_IMP(a_phase_range, clk, rst_n, 1'b1, ph_r <= PH_IDLE, "bad phase")
endmodule

// File: src/mtp_queue.sv
`timescale 1ns / 1ps
module mtp_queue #(
  parameter int TICK_BITS = mtp_pkg::TICK_BITS_DEF,
  parameter int DEPTH = mtp_pkg::FIFO_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr,
  input  mtp_pkg::rec_t        wr_rec,
  input  logic [TICK_BITS-1:0] wr_tick,
  output logic                 full,
  output logic                 empty,
  input  logic                 rd,
  output mtp_pkg::rec_t        rd_rec,
  output logic [TICK_BITS-1:0] rd_tick
);
  import mtp_pkg::*;
  `include "midi_track_event_parser_macros.svh"

  localparam int AW = $clog2(DEPTH);

  rec_t rec_q [DEPTH];
  logic [TICK_BITS-1:0] tick_q [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0] cnt_r;
  logic do_wr, do_rd;

  assign full = cnt_r == (AW+1)'(DEPTH);
  assign empty = cnt_r == '0;
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rd_rec = rec_q[rp_r];
  assign rd_tick = tick_q[rp_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      rec_q[wp_r] <= wr_rec;
      tick_q[wp_r] <= wr_tick;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (do_wr) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + AW'(1);
      if (do_rd) rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + AW'(1);
      cnt_r <= cnt_r + (AW+1)'(do_wr) - (AW+1)'(do_rd);
    end
  end

  `MTP_ASSERT_IMP(a_no_over, clk, rst_n, 1'b1, cnt_r <= (AW+1)'(DEPTH), "queue overflow")
  `MTP_ASSERT_NXT(a_cnt, clk, rst_n, do_wr && !do_rd, cnt_r == $past(cnt_r) + 1'b1,
    "count slip")
  `MTP_ASSERT_IMP(a_wr_ok, clk, rst_n, wr, !full, "write into full queue")
endmodule

// File: src/midi_track_event_parser.sv
`timescale 1ns / 1ps
// Track chunk parser: push one byte of a MIDI track chunk per cycle while
// full is low (delta times, channel messages with running status, system,
// SysEx and meta records) and pop at most one event per byte from a small
// output queue. The parser decides on each byte combinationally and writes
// its event into a four-entry queue, so full rises only when the popping
// side falls behind by four events. Events come out with the tick of the
// record (saturating at 2^TICK_BITS-1) and the per-track order.
// Errors park the parser until the next byte flagged track_start.
module midi_track_event_parser #(
  parameter int TICK_BITS = mtp_pkg::TICK_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_chunk_last,
  input  logic                 in_track_start,
  output logic                 empty,
  input  logic                 pop,
  output logic [2:0]           out_event_kind,
  output logic [TICK_BITS-1:0] out_event_tick,
  output logic [31:0]          out_event_order,
  output logic [23:0]          out_channel_message,
  output logic [23:0]          out_tempo_value,
  output logic [27:0]          out_payload_length,
  output logic [7:0]           out_payload_byte,
  output logic                 out_payload_last,
  output logic [3:0]           out_error_code
);
  import mtp_pkg::*;

  logic accept, rec_valid;
  rec_t rec, head;
  logic [TICK_BITS-1:0] rec_tick;

  // Hold input bytes back only while the queue is full.
  assign accept = push && !full;

  mtp_front #(.TICK_BITS(TICK_BITS)) u_front (
    .clk, .rst_n, .valid(accept), .data_byte(in_data_byte),
    .chunk_last(in_chunk_last), .track_start(in_track_start),
    .rec_valid, .rec, .rec_tick
  );

  mtp_queue #(.TICK_BITS(TICK_BITS), .DEPTH(FIFO_DEPTH)) u_queue (
    .clk, .rst_n, .wr(rec_valid), .wr_rec(rec), .wr_tick(rec_tick),
    .full, .empty, .rd(pop), .rd_rec(head), .rd_tick(out_event_tick)
  );

  assign out_event_kind = head.kind;
  assign out_event_order = head.order;
  assign out_channel_message = head.msg;
  assign out_tempo_value = head.tempo;
  assign out_payload_length = head.len;
  assign out_payload_byte = head.pbyte;
  assign out_payload_last = head.plast;
  assign out_error_code = head.err;
endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import mtp_pkg::*;

  // Parse phases of the track decoder, mirrored here for prediction.
  typedef enum logic [3:0] {
    PH_DELTA, PH_STATUS, PH_META_TYPE, PH_META_LEN, PH_META_DATA,
    PH_SYSEX_LEN, PH_SYSEX_DATA, PH_SYS_DATA, PH_CH_D1, PH_CH_D2, PH_IDLE
  } phase_e;

  // One decoded track event as it should leave the block.
  typedef struct packed {
    logic        vld;
    logic [2:0]  kind;
    logic [47:0] tick;
    logic [31:0] order;
    logic [23:0] msg;
    logic [23:0] tempo;
    logic [27:0] len;
    logic [7:0]  pbyte;
    logic        plast;
    logic [3:0]  err;
  } track_event_t;

  // One chunk byte request; chk marks a row whose result is typed in.
  typedef struct packed {
    logic [7:0] d;
    logic       last;
    logic       ts;
    logic       chk;
    logic [2:0] kind;
    logic [3:0] err;
  } byte_req_t;

  localparam int DIR_ROWS = 36;
  localparam int RANDOM_ITEMS = 900;
  localparam int STALL_LIMIT = 2000;
  localparam logic [47:0] TICK_MAX = 48'hffff_ffff_ffff;

  // Hand-built opening: a small well-formed track, then the error paths.
  byte_req_t dir_tab [0:DIR_ROWS-1] = '{
    '{8'h00, 1'b0, 1'b1, 1'b0, K_CHANNEL, E_NONE},   // new track, delta 0
    '{8'h90, 1'b0, 1'b0, 1'b0, K_CHANNEL, E_NONE},   // note on
    '{8'h3c, 1'b0, 1'b0, 1'b0, K_CHANNEL, E_NONE},
    '{8'h7f, 1'b0, 1'b0, 1'b1, K_CHANNEL, E_NONE},
    '{8'h81, 1'b0, 1'b0, 1'b0, K_CHANNEL, E_NONE},   // two-byte delta
    '{8'h00, 1'b0, 1'b0, 1'b0, K_CHANNEL, E_NONE},
    '{8'h40, 1'b0, 1'b0, 1'b0, K_CHANNEL, E_NONE},   // running status
    '{8'h00, 1'b0, 1'b0, 1'b1, K_CHANNEL, E_NONE},
    '{8'h00, 1'b0, 1'b0, 1'b0, K_CHANNEL, E_NONE},
    '{8'hc5, 1'b0, 1'b0, 1'b0, K_CHANNEL, E_NONE},   // program change
    '{8'h12, 1'b0, 1'b0, 1'b1, K_CHANNEL, E_NONE},
    '{8'h00, 1'b0, 1'b0, 1'b0, K_CHANNEL, E_NONE},
    '{8'hf0, 1'b0, 1'b0, 1'b0, K_CHANNEL, E_NONE},   // sysex, two bytes
    '{8'h02, 1'b0, 1'b0, 1'b1, K_SX_HDR,  E_NONE},
    '{8'h11, 1'b0, 1'b0, 1'b1, K_SX_BYTE, E_NONE},
    '{8'hf7, 1'b0, 1'b0, 1'b1, K_SX_BYTE, E_NONE},
    '{8'h00, 1'b0, 1'b0, 1'b0, K_CHANNEL, E_NONE},
    '{8'hff, 1'b0, 1'b0, 1'b0, K_CHANNEL, E_NONE},   // tempo meta
    '{8'h51, 1'b0, 1'b0, 1'b0, K_CHANNEL, E_NONE},
    '{8'h03, 1'b0, 1'b0, 1'b0, K_CHANNEL, E_NONE},
    '{8'hff, 1'b0, 1'b0, 1'b0, K_CHANNEL, E_NONE},
    '{8'hff, 1'b0, 1'b0, 1'b0, K_CHANNEL, E_NONE},
    '{8'hff, 1'b0, 1'b0, 1'b1, K_TEMPO,   E_NONE},
    '{8'h00, 1'b0, 1'b0, 1'b0, K_CHANNEL, E_NONE},
    '{8'hf6, 1'b0, 1'b0, 1'b1, K_SYSTEM,  E_NONE},   // tune request
    '{8'h00, 1'b0, 1'b0, 1'b0, K_CHANNEL, E_NONE},
    '{8'hff, 1'b0, 1'b0, 1'b0, K_CHANNEL, E_NONE},   // end of track
    '{8'h2f, 1'b0, 1'b0, 1'b0, K_CHANNEL, E_NONE},
    '{8'h00, 1'b0, 1'b0, 1'b1, K_EOT,     E_NONE},
    '{8'h80, 1'b0, 1'b1, 1'b0, K_CHANNEL, E_NONE},   // delta too long
    '{8'h80, 1'b0, 1'b0, 1'b0, K_CHANNEL, E_NONE},
    '{8'h80, 1'b0, 1'b0, 1'b0, K_CHANNEL, E_NONE},
    '{8'h80, 1'b0, 1'b0, 1'b1, K_ERROR,   E_DELTA},
    '{8'h00, 1'b0, 1'b1, 1'b0, K_CHANNEL, E_NONE},   // data with no status
    '{8'h40, 1'b0, 1'b0, 1'b1, K_ERROR,   E_RUNNING},
    '{8'h05, 1'b1, 1'b1, 1'b1, K_ERROR,   E_TRUNC}   // chunk ends after delta
  };

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  logic [7:0]  in_data_byte;
  logic        in_chunk_last;
  logic        in_track_start;
  logic        empty;
  logic        pop;
  logic [2:0]  out_event_kind;
  logic [47:0] out_event_tick;
  logic [31:0] out_event_order;
  logic [23:0] out_channel_message;
  logic [23:0] out_tempo_value;
  logic [27:0] out_payload_length;
  logic [7:0]  out_payload_byte;
  logic        out_payload_last;
  logic [3:0]  out_error_code;

  midi_track_event_parser dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .push                (push),
    .full                (full),
    .in_data_byte        (in_data_byte),
    .in_chunk_last       (in_chunk_last),
    .in_track_start      (in_track_start),
    .empty               (empty),
    .pop                 (pop),
    .out_event_kind      (out_event_kind),
    .out_event_tick      (out_event_tick),
    .out_event_order     (out_event_order),
    .out_channel_message (out_channel_message),
    .out_tempo_value     (out_tempo_value),
    .out_payload_length  (out_payload_length),
    .out_payload_byte    (out_payload_byte),
    .out_payload_last    (out_payload_last),
    .out_error_code      (out_error_code)
  );

  byte_req_t    byte_reqs [$];
  track_event_t pending_events [$];
  int           bytes_taken;
  int           events_checked;
  int           errors_checked;
  int           fail_count;
  int           stall_cycles;
  bit           running_ok;

  // Decoder state used for prediction.
  phase_e      ph;
  logic [47:0] tick_acc;
  logic [27:0] qty_acc;
  logic [2:0]  qty_cnt;
  logic [7:0]  run_status;
  logic [7:0]  cur_status;
  logic [7:0]  data1;
  logic [7:0]  meta_kind;
  logic [23:0] tempo_acc;
  logic [27:0] remain;
  logic [31:0] rec_count;
  logic        done_flag;
  logic        err_flag;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Data bytes after a system common status, by its low nibble.
  function automatic int sys_data_len(input logic [7:0] st);
    case (st[3:0])
      4'h1, 4'h3: return 1;
      4'h2:       return 2;
      default:    return 0;
    endcase
  endfunction

  function automatic void clear_track();
    ph = PH_DELTA;
    tick_acc = '0;
    qty_acc = '0;
    qty_cnt = '0;
    run_status = '0;
    cur_status = '0;
    data1 = '0;
    meta_kind = '0;
    tempo_acc = '0;
    remain = '0;
    rec_count = '0;
    done_flag = 1'b0;
    err_flag = 1'b0;
  endfunction

  function automatic track_event_t make_event(input logic [2:0] kind, input logic [31:0] order,
      input logic [23:0] msg, input logic [23:0] tempo, input logic [27:0] len,
      input logic [7:0] pbyte, input logic plast, input logic [3:0] err);
    track_event_t e;
    e = '{vld: 1'b1, kind: kind, tick: tick_acc, order: order, msg: msg, tempo: tempo,
          len: len, pbyte: pbyte, plast: plast, err: err};
    return e;
  endfunction

  // Park the decoder until the next track start.
  function automatic track_event_t abort_track(input logic [3:0] code);
    err_flag = 1'b1;
    ph = PH_IDLE;
    return make_event(K_ERROR, rec_count, '0, '0, '0, '0, 1'b0, code);
  endfunction

  // Close a record: back to delta, or done when the chunk ends here.
  function automatic track_event_t close_record(input logic last, input logic [2:0] kind,
      input logic [23:0] msg, input logic [23:0] tempo, input logic [27:0] len,
      input logic [7:0] pbyte, input logic plast);
    ph = PH_DELTA;
    if (last) begin
      ph = PH_IDLE;
      done_flag = 1'b1;
    end
    return make_event(kind, rec_count - 32'd1, msg, tempo, len, pbyte, plast, E_NONE);
  endfunction

  // Shift in one quantity byte; true while more bytes follow.
  function automatic logic qty_shift(input logic [7:0] b);
    qty_acc = {qty_acc[20:0], b[6:0]};
    qty_cnt = qty_cnt + 3'd1;
    return b[7];
  endfunction

  function automatic track_event_t close_meta(input logic last);
    track_event_t e;
    if (meta_kind == META_EOT) begin
      e = close_record(last, K_EOT, '0, '0, '0, '0, 1'b0);
      ph = PH_IDLE;
      done_flag = 1'b1;
      return e;
    end
    if (meta_kind == META_TEMPO && qty_acc == 28'd3 && tempo_acc != '0)
      return close_record(last, K_TEMPO, '0, tempo_acc, '0, '0, 1'b0);
    return close_record(last, K_META, '0, '0, '0, '0, 1'b0);
  endfunction

  function automatic track_event_t take_first_data(input logic [7:0] b, input logic last);
    track_event_t none;
    none = '0;
    data1 = b;
    if (cur_status[7:4] == 4'hc || cur_status[7:4] == 4'hd) begin
      if (b[7]) return abort_track(E_DATA);
      return close_record(last, K_CHANNEL, {8'h00, b, cur_status}, '0, '0, '0, 1'b0);
    end
    if (last) return abort_track(E_CHANNEL);
    ph = PH_CH_D2;
    return none;
  endfunction

  // Advance the decoder by one chunk byte; vld marks an event.
  function automatic track_event_t parse_byte(input logic [7:0] b, input logic last,
      input logic ts);
    track_event_t none;
    int n;
    none = '0;
    if (ts) clear_track();
    if (ph == PH_IDLE || err_flag || done_flag) return none;
    case (ph)
      PH_DELTA: begin
        if (qty_shift(b)) begin
          if (qty_cnt >= 3'd4 || last) return abort_track(E_DELTA);
          return none;
        end
        if ({20'd0, qty_acc} > TICK_MAX - tick_acc) tick_acc = TICK_MAX;
        else tick_acc = tick_acc + {20'd0, qty_acc};
        qty_acc = '0;
        qty_cnt = '0;
        if (last) return abort_track(E_TRUNC);
        ph = PH_STATUS;
        return none;
      end
      PH_STATUS: begin
        if (!b[7]) begin
          if (run_status < 8'h80 || run_status >= 8'hf0) return abort_track(E_RUNNING);
          cur_status = run_status;
          rec_count = rec_count + 32'd1;
          return take_first_data(b, last);
        end
        rec_count = rec_count + 32'd1;
        cur_status = b;
        run_status = (b < 8'hf0) ? b : 8'h00;
        qty_acc = '0;
        qty_cnt = '0;
        if (b == ST_META) begin
          if (last) return abort_track(E_META);
          ph = PH_META_TYPE;
          return none;
        end
        if (b == ST_SYSEX || b == ST_ESC) begin
          if (last) return abort_track(E_SYSEX);
          ph = PH_SYSEX_LEN;
          return none;
        end
        if (b >= 8'hf0) begin
          n = sys_data_len(b);
          if (n == 0) return close_record(last, K_SYSTEM, '0, '0, '0, '0, 1'b0);
          if (last) return abort_track(E_SYSTEM);
          remain = 28'(n);
          ph = PH_SYS_DATA;
          return none;
        end
        if (last) return abort_track(E_CHANNEL);
        ph = PH_CH_D1;
        return none;
      end
      PH_CH_D1: return take_first_data(b, last);
      PH_CH_D2: begin
        if (data1[7] || b[7]) return abort_track(E_DATA);
        return close_record(last, K_CHANNEL, {b, data1, cur_status}, '0, '0, '0, 1'b0);
      end
      PH_META_TYPE: begin
        meta_kind = b;
        qty_acc = '0;
        qty_cnt = '0;
        if (last) return abort_track(E_META);
        ph = PH_META_LEN;
        return none;
      end
      PH_META_LEN: begin
        if (qty_shift(b)) begin
          if (qty_cnt >= 3'd4 || last) return abort_track(E_META);
          return none;
        end
        tempo_acc = '0;
        remain = qty_acc;
        if (remain == '0) return close_meta(last);
        if (last) return abort_track(E_META);
        ph = PH_META_DATA;
        return none;
      end
      PH_META_DATA: begin
        if (meta_kind == META_TEMPO) tempo_acc = {tempo_acc[15:0], b};
        remain = remain - 28'd1;
        if (remain == '0) return close_meta(last);
        if (last) return abort_track(E_META);
        return none;
      end
      PH_SYSEX_LEN: begin
        if (qty_shift(b)) begin
          if (qty_cnt >= 3'd4 || last) return abort_track(E_SYSEX);
          return none;
        end
        remain = qty_acc;
        if (remain == '0) return close_record(last, K_SX_HDR, '0, '0, '0, '0, 1'b0);
        if (last) return abort_track(E_SYSEX);
        ph = PH_SYSEX_DATA;
        return make_event(K_SX_HDR, rec_count - 32'd1, '0, '0, qty_acc, '0, 1'b0, E_NONE);
      end
      PH_SYSEX_DATA: begin
        remain = remain - 28'd1;
        if (remain == '0) return close_record(last, K_SX_BYTE, '0, '0, '0, b, 1'b1);
        if (last) return abort_track(E_SYSEX);
        return make_event(K_SX_BYTE, rec_count - 32'd1, '0, '0, '0, b, 1'b0, E_NONE);
      end
      PH_SYS_DATA: begin
        remain = remain - 28'd1;
        if (remain == '0) return close_record(last, K_SYSTEM, '0, '0, '0, '0, 1'b0);
        if (last) return abort_track(E_SYSTEM);
        return none;
      end
      default: begin
        ph = PH_IDLE;
        return none;
      end
    endcase
  endfunction

  // Append one chunk byte to the request list.
  task automatic add_byte(input logic [7:0] d, input logic ts);
    byte_reqs.insert(byte_reqs.size(), byte_req_t'{d, 1'b0, ts, 1'b0, K_CHANNEL, E_NONE});
  endtask

  // Delta time: mostly one byte, sometimes up to four, rarely too long.
  task automatic add_delta(input logic ts);
    int n;
    int r;
    r = $urandom_range(0, 99);
    n = (r < 60) ? 1 : (r < 97) ? $urandom_range(2, 4) : 5;
    for (int i = 0; i < n; i++)
      add_byte({(i != n - 1), 7'($urandom)}, ts && i == 0);
  endtask

  // Build one random track: well-formed records, some noise, then an end.
  task automatic add_track();
    int first;
    int r;
    int n;
    logic [7:0] st;
    first = byte_reqs.size();
    running_ok = 1'b0;
    for (int rec = 0; rec < $urandom_range(1, 10); rec++) begin
      add_delta(rec == 0);
      r = $urandom_range(0, 99);
      if (r < 45) begin
        st = 8'($urandom_range(8'h80, 8'hef));
        if (running_ok && $urandom_range(0, 1)) st = byte_reqs[$].d;
        else add_byte(st, 1'b0);
        running_ok = 1'b1;
        n = (st[7:4] == 4'hc || st[7:4] == 4'hd) ? 1 : 2;
        // running status reuses the last status byte sent only if it was one
        if (!byte_reqs[$].d[7] && byte_reqs[$].d != st) n = n;
        for (int i = 0; i < n; i++)
          add_byte(($urandom_range(0, 32) == 0) ? 8'($urandom) : 8'($urandom_range(0, 127)),
                   1'b0);
      end else if (r < 55) begin
        st = {4'hf, 4'($urandom)};
        if (st == ST_SYSEX || st == ST_ESC || st == ST_META) st = 8'hf2;
        add_byte(st, 1'b0);
        running_ok = 1'b0;
        for (int i = 0; i < sys_data_len(st); i++) add_byte(8'($urandom_range(0, 127)), 1'b0);
      end else if (r < 70) begin
        add_byte($urandom_range(0, 1) ? ST_SYSEX : ST_ESC, 1'b0);
        running_ok = 1'b0;
        n = $urandom_range(0, 6);
        add_byte(8'(n), 1'b0);
        for (int i = 0; i < n; i++) add_byte(8'($urandom), 1'b0);
      end else if (r < 92) begin
        add_byte(ST_META, 1'b0);
        running_ok = 1'b0;
        if ($urandom_range(0, 2) == 0) begin
          add_byte(META_TEMPO, 1'b0);
          n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : 3;
        end else begin
          st = 8'($urandom);
          add_byte((st == META_EOT) ? 8'h01 : st, 1'b0);
          n = $urandom_range(0, 4);
        end
        if ($urandom_range(0, 4) == 0) add_byte(8'h80, 1'b0);  // padded length
        add_byte(8'(n), 1'b0);
        for (int i = 0; i < n; i++)
          add_byte(($urandom_range(0, 5) == 0) ? 8'h00 : 8'($urandom), 1'b0);
      end else begin
        add_byte(8'($urandom), 1'b0);  // noise
        running_ok = 1'b0;
      end
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      add_byte(8'h00, 1'b0);
      add_byte(ST_META, 1'b0);
      add_byte(META_EOT, 1'b0);
      add_byte(8'h00, 1'b0);
    end
    if (r < 80) byte_reqs[$].last = 1'b1;
    else if (r < 92) byte_reqs[$urandom_range(first, byte_reqs.size() - 1)].last = 1'b1;
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $display("%0t mismatch on %s: expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Predict on each accepted request; check each popped event in order.
  always @(posedge clk) begin
    track_event_t e;
    byte_req_t    q;
    bit           moved;
    moved = 1'b0;
    if (rst_n && push && !full) begin
      q = byte_reqs[bytes_taken];
      e = parse_byte(in_data_byte, in_chunk_last, in_track_start);
      if (q.chk && (!e.vld || e.kind != q.kind || e.err != q.err)) begin
        $display("%0t mismatch on opening row %0d: expected kind %0d code %0d, actual %0d %0d",
                 $time, bytes_taken, q.kind, q.err, e.kind, e.err);
        fail_count++;
      end
      if (e.vld) pending_events.insert(pending_events.size(), e);
      bytes_taken++;
      moved = 1'b1;
    end
    if (rst_n && pop && !empty) begin
      moved = 1'b1;
      if (pending_events.size() == 0) begin
        $display("%0t unexpected event: expected none, actual kind %0d", $time, out_event_kind);
        fail_count++;
      end else begin
        e = pending_events.pop_front();
        check_field("event_kind", e.kind, out_event_kind);
        check_field("event_tick", e.tick, out_event_tick);
        check_field("event_order", e.order, out_event_order);
        check_field("channel_message", e.msg, out_channel_message);
        check_field("tempo_value", e.tempo, out_tempo_value);
        check_field("payload_length", e.len, out_payload_length);
        check_field("payload_byte", e.pbyte, out_payload_byte);
        check_field("payload_last", e.plast, out_payload_last);
        check_field("error_code", e.err, out_error_code);
        events_checked++;
        if (e.kind == K_ERROR) errors_checked++;
      end
    end
    stall_cycles <= moved ? 0 : stall_cycles + 1;
  end

  // Stop the run when nothing moves for too long.
  always @(posedge clk) begin
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Result side: random gaps before each pop, with quiet stretches.
  initial begin
    int  g;
    int  k;
    bit  quiet;
    logic e;
    k = 0;
    quiet = 1'b0;
    @(posedge rst_n);
    forever begin
      if (k % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
      k++;
      g = quiet ? 0 : $urandom_range(0, 4);
      if (g != 0) begin
        pop <= 1'b0;
        repeat (g) @(posedge clk);
      end
      pop <= 1'b1;
      do begin
        @(negedge clk);
        e = empty;
        @(posedge clk);
      end while (e);
    end
  end

  // Request side and end of run.
  initial begin
    int   g;
    int   drain;
    bit   quiet;
    logic f;
    byte_req_t q;
    push = 1'b0;
    pop = 1'b0;
    in_data_byte = '0;
    in_chunk_last = 1'b0;
    in_track_start = 1'b0;
    rst_n = 1'b0;
    bytes_taken = 0;
    events_checked = 0;
    errors_checked = 0;
    fail_count = 0;
    stall_cycles = 0;
    quiet = 1'b0;
    clear_track();
    foreach (dir_tab[i]) byte_reqs.insert(byte_reqs.size(), dir_tab[i]);
    while (byte_reqs.size() < DIR_ROWS + RANDOM_ITEMS) add_track();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < byte_reqs.size(); i++) begin
      q = byte_reqs[i];
      if (i % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
      g = quiet ? 0 : $urandom_range(0, 4);
      // hold off once mid-run until every pending event has drained
      if (i == DIR_ROWS + RANDOM_ITEMS / 2) begin
        push <= 1'b0;
        @(posedge clk);
        while (pending_events.size() != 0) @(posedge clk);
      end else if (g != 0) begin
        push <= 1'b0;
        repeat (g) @(posedge clk);
      end
      push <= 1'b1;
      in_data_byte <= q.d;
      in_chunk_last <= q.last;
      in_track_start <= q.ts;
      do begin
        @(negedge clk);
        f = full;
        @(posedge clk);
      end while (f);
    end
    push <= 1'b0;
    drain = 0;
    while (pending_events.size() != 0 && drain < STALL_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (8) @(posedge clk);
    $display("Run covered %0d chunk bytes and %0d checked events, %0d of them errors.",
             bytes_taken, events_checked, errors_checked);
    if (fail_count == 0 && pending_events.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d events never seen", fail_count, pending_events.size());
      $display("FAILURE");
    end
    $finish;
  end
endmodule
